FILE: sv/cpd_pkg.sv
// Shared constants, codes and types for the Canberra pairwise distance core.
`timescale 1ns / 1ps
package cpd_pkg;

  localparam int unsigned CPD_MAX_ROWS    = 8;
  localparam int unsigned CPD_MAX_COLUMNS = 16;

  // Fixed field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned TERM_W  = 17;
  localparam int unsigned DIST_W  = 21;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // Request commands
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Pairing modes
  typedef enum logic [1:0] {
    MODE_CONDENSED = 2'd0,
    MODE_FULL      = 2'd1,
    MODE_CROSS     = 2'd2,
    MODE_INVALID   = 2'd3
  } mode_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd3;

endpackage

FILE: sv/cpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cpd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered; a read of the entry being written returns its old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/cpd_div.sv
// Restoring divider giving floor(num * 2^16 / den), one quotient bit per cycle.
`timescale 1ns / 1ps
module cpd_div
  import cpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VALUE_W-1:0] num,
  input  logic [TERM_W-1:0] den,
  output logic              done,
  output logic [TERM_W-1:0] quo
);

  localparam int unsigned REM_W = TERM_W + 1;
  localparam int unsigned CNT_W = $clog2(TERM_W + 1);

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [TERM_W-1:0] den_r, den_nxt;
  logic [TERM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [REM_W:0]    diff;
  logic [REM_W-1:0]  rem_keep;

  // One trial subtraction per cycle; the numerator never exceeds the divisor.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    diff     = {1'b0, rem_r} - {2'b00, den_r};
    rem_keep = rem_r;
    if (start) begin
      rem_nxt = REM_W'(num);
      den_nxt = den;
      quo_nxt = '0;
      cnt_nxt = CNT_W'(TERM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[REM_W]) begin
        quo_nxt  = {quo_r[TERM_W-2:0], 1'b1};
        rem_keep = diff[REM_W-1:0];
      end else begin
        quo_nxt  = {quo_r[TERM_W-2:0], 1'b0};
      end
      rem_nxt = {rem_keep[REM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      den_r  <= '0;
      quo_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      den_r  <= den_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: sv/canberra_pairwise_distance_core.sv
// Top level of the Canberra pairwise distance core: stores, sequencer, accumulator.
`timescale 1ns / 1ps
//
//  Channel  Ports                                  Handshake
//  -------  -------------------------------------  ---------------------------
//  input    in_command, in_value                   start high while busy low
//  result   out_distance, out_row_first/second,    out_valid strobe, one cycle
//           out_last
//  config   cfg_index, cfg_data                    cfg_valid and cfg_ready
//
//  A load request leaves busy low, so loads stream one per cycle.
//  A run works through each pair column by column: S_READ addresses the stores,
//  S_FETCH takes the read data, and the bit-serial divider in S_DIV sets the pace.
//  Reset is synchronous and active low; the stores are not cleared.
//  Results cannot be stalled; each pair is presented for exactly one cycle.
//
module canberra_pairwise_distance_core
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = CPD_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = CPD_MAX_COLUMNS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                  out_valid,
  output logic [DIST_W-1:0]     out_distance,
  output logic [ROW_W-1:0]      out_row_first,
  output logic [ROW_W-1:0]      out_row_second,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PTR_W = $clog2(DEPTH + 1);
  localparam int unsigned RIW   = $clog2(MAX_ROWS);
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned PW    = RIW + CNW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FETCH,
    S_DIV
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [3:0]         rows_a_r, rows_a_nxt;
  logic [3:0]         rows_b_r, rows_b_nxt;
  logic [4:0]         cols_cfg_r, cols_cfg_nxt;
  logic [PTR_W-1:0]   ptr_a_r, ptr_a_nxt;
  logic [PTR_W-1:0]   ptr_b_r, ptr_b_nxt;
  logic               cross_r, cross_nxt;
  logic               cond_r, cond_nxt;
  logic [CNW-1:0]     cols_r, cols_nxt;
  logic [RIW-1:0]     ilast_r, ilast_nxt;
  logic [RIW-1:0]     jlast_r, jlast_nxt;
  logic [RIW-1:0]     i_r, i_nxt;
  logic [RIW-1:0]     j_r, j_nxt;
  logic [CNW-1:0]     c_r, c_nxt;
  logic [DIST_W-1:0]  sum_r, sum_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [ROW_W-1:0]   out_first_r, out_first_nxt;
  logic [ROW_W-1:0]   out_second_r, out_second_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               we_a, we_b;
  logic [PW-1:0]      addr_first, addr_second;
  logic [VALUE_W-1:0] rd_a1, rd_a2, rd_b;
  logic signed [VALUE_W-1:0] op_x, op_y;
  logic [VALUE_W:0]   abs_x, abs_y;
  logic signed [VALUE_W:0] delta;
  logic [VALUE_W:0]   abs_d;
  logic [TERM_W-1:0]  den;
  logic               div_start, div_done;
  logic [TERM_W-1:0]  quo;
  logic [TERM_W-1:0]  term;
  logic [DIST_W:0]    sum_add;
  logic [DIST_W-1:0]  sum_sat;
  logic               last_pair;
  logic [RCW-1:0]     ra_eff, rb_eff;
  logic [CNW-1:0]     cols_eff;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign we_a = accept && (in_command == CMD_LOAD_A) && (ptr_a_r < PTR_W'(DEPTH));
  assign we_b = accept && (in_command == CMD_LOAD_B) && (ptr_b_r < PTR_W'(DEPTH));

  // Clamp the row and column registers into the supported range.
  always_comb begin
    if (rows_a_r == 4'd0) ra_eff = RCW'(1);
    else if (32'(rows_a_r) > MAX_ROWS) ra_eff = RCW'(MAX_ROWS);
    else ra_eff = RCW'(rows_a_r);
    if (rows_b_r == 4'd0) rb_eff = RCW'(1);
    else if (32'(rows_b_r) > MAX_ROWS) rb_eff = RCW'(MAX_ROWS);
    else rb_eff = RCW'(rows_b_r);
    if (cols_cfg_r == 5'd0) cols_eff = CNW'(1);
    else if (32'(cols_cfg_r) > MAX_COLUMNS) cols_eff = CNW'(MAX_COLUMNS);
    else cols_eff = CNW'(cols_cfg_r);
  end

  // Element (r,c) sits at r * columns + c.
  assign addr_first  = PW'(i_r) * PW'(cols_r) + PW'(c_r);
  assign addr_second = PW'(j_r) * PW'(cols_r) + PW'(c_r);

  // Matrix A is held twice so both rows of a pair can be read in the same cycle.
  cpd_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a1 (
    .clk(clk), .we(we_a), .waddr(ptr_a_r[AW-1:0]), .wdata(in_value),
    .raddr(addr_first[AW-1:0]), .rdata(rd_a1)
  );
  cpd_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a2 (
    .clk(clk), .we(we_a), .waddr(ptr_a_r[AW-1:0]), .wdata(in_value),
    .raddr(addr_second[AW-1:0]), .rdata(rd_a2)
  );
  cpd_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(ptr_b_r[AW-1:0]), .wdata(in_value),
    .raddr(addr_second[AW-1:0]), .rdata(rd_b)
  );

  // Numerator and denominator of one term.
  always_comb begin
    op_x  = signed'(rd_a1);
    op_y  = cross_r ? signed'(rd_b) : signed'(rd_a2);
    abs_x = op_x[VALUE_W-1] ? (VALUE_W+1)'(-32'(op_x)) : (VALUE_W+1)'(op_x);
    abs_y = op_y[VALUE_W-1] ? (VALUE_W+1)'(-32'(op_y)) : (VALUE_W+1)'(op_y);
    delta = (VALUE_W+1)'(op_x) - (VALUE_W+1)'(op_y);
    abs_d = delta[VALUE_W] ? (VALUE_W+1)'(-delta) : (VALUE_W+1)'(delta);
    den   = TERM_W'(abs_x + abs_y);
  end

  assign div_start = (state_r == S_FETCH);

  cpd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(abs_d[VALUE_W-1:0]), .den(den), .done(div_done), .quo(quo)
  );

  // A zero denominator contributes nothing; the sum saturates.
  assign term    = zero_r ? '0 : quo;
  assign sum_add = (DIST_W+1)'(sum_r) + (DIST_W+1)'(term);
  assign sum_sat = sum_add[DIST_W] ? '1 : sum_add[DIST_W-1:0];
  assign last_pair = (i_r == ilast_r) && (j_r == jlast_r);

  // Sequencer, configuration and load pointers.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    rows_a_nxt     = rows_a_r;
    rows_b_nxt     = rows_b_r;
    cols_cfg_nxt   = cols_cfg_r;
    ptr_a_nxt      = ptr_a_r;
    ptr_b_nxt      = ptr_b_r;
    cross_nxt      = cross_r;
    cond_nxt       = cond_r;
    cols_nxt       = cols_r;
    ilast_nxt      = ilast_r;
    jlast_nxt      = jlast_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    c_nxt          = c_r;
    sum_nxt        = sum_r;
    zero_nxt       = zero_r;
    out_valid_nxt  = 1'b0;
    out_dist_nxt   = out_dist_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_last_nxt   = out_last_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: begin
          if (cfg_data[1:0] != MODE_INVALID) mode_nxt = cfg_data[1:0];
        end
        REG_ROWS_A:  rows_a_nxt   = cfg_data[3:0];
        REG_ROWS_B:  rows_b_nxt   = cfg_data[3:0];
        REG_COLUMNS: cols_cfg_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (we_a) ptr_a_nxt = ptr_a_r + PTR_W'(1);
        if (we_b) ptr_b_nxt = ptr_b_r + PTR_W'(1);
        if (accept && (in_command == CMD_RUN)) begin
          ptr_a_nxt = '0;
          ptr_b_nxt = '0;
          cross_nxt = (mode_r == MODE_CROSS);
          cond_nxt  = (mode_r == MODE_CONDENSED);
          cols_nxt  = cols_eff;
          i_nxt     = '0;
          c_nxt     = '0;
          sum_nxt   = '0;
          if (mode_r == MODE_CONDENSED) begin
            ilast_nxt = RIW'(ra_eff - RCW'(2));
            jlast_nxt = RIW'(ra_eff - RCW'(1));
            j_nxt     = RIW'(1);
            // A single row has no pair above the diagonal.
            if (ra_eff != RCW'(1)) state_nxt = S_READ;
          end else begin
            ilast_nxt = RIW'(ra_eff - RCW'(1));
            jlast_nxt = (mode_r == MODE_CROSS) ? RIW'(rb_eff - RCW'(1))
                                               : RIW'(ra_eff - RCW'(1));
            j_nxt     = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_FETCH;
      S_FETCH: begin
        zero_nxt  = (den == '0);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (c_r == cols_r - CNW'(1)) begin
            // Pair complete: present it and move to the next pair, or to idle after the last one.
            out_valid_nxt  = 1'b1;
            out_dist_nxt   = sum_sat;
            out_first_nxt  = ROW_W'(i_r);
            out_second_nxt = ROW_W'(j_r);
            out_last_nxt   = last_pair;
            sum_nxt        = '0;
            c_nxt          = '0;
            if (last_pair) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_READ;
              if (j_r == jlast_r) begin
                i_nxt = i_r + RIW'(1);
                j_nxt = cond_r ? RIW'(i_r + RIW'(2)) : '0;
              end else begin
                j_nxt = j_r + RIW'(1);
              end
            end
          end else begin
            sum_nxt   = sum_sat;
            c_nxt     = c_r + CNW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_FULL;
      rows_a_r     <= 4'd8;
      rows_b_r     <= 4'd8;
      cols_cfg_r   <= 5'd16;
      ptr_a_r      <= '0;
      ptr_b_r      <= '0;
      cross_r      <= 1'b0;
      cond_r       <= 1'b0;
      cols_r       <= CNW'(1);
      ilast_r      <= '0;
      jlast_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      c_r          <= '0;
      sum_r        <= '0;
      zero_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_dist_r   <= '0;
      out_first_r  <= '0;
      out_second_r <= '0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      rows_a_r     <= rows_a_nxt;
      rows_b_r     <= rows_b_nxt;
      cols_cfg_r   <= cols_cfg_nxt;
      ptr_a_r      <= ptr_a_nxt;
      ptr_b_r      <= ptr_b_nxt;
      cross_r      <= cross_nxt;
      cond_r       <= cond_nxt;
      cols_r       <= cols_nxt;
      ilast_r      <= ilast_nxt;
      jlast_r      <= jlast_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      c_r          <= c_nxt;
      sum_r        <= sum_nxt;
      zero_r       <= zero_nxt;
      out_valid_r  <= out_valid_nxt;
      out_dist_r   <= out_dist_nxt;
      out_first_r  <= out_first_nxt;
      out_second_r <= out_second_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_dist_r;
  assign out_row_first  = out_first_r;
  assign out_row_second = out_second_r;
  assign out_last       = out_last_r;

  // A result only follows a finished division.
  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DIV) && $past(div_done))
    else $error("result without a finished division");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("division finished outside the wait state");

  // The final result of a run returns the core to idle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy && ptr_a_r == '0 && ptr_b_r == '0)
    else $error("last result while the run is still active");

endmodule
